// ===== sv/pab_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pab_pkg
// Shared types, register map and arithmetic helpers for the alpha blend
// pixel writer.
// ----------------------------------------------------------------------------
package pab_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int DIM_W      = 13;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [2:0]       FORMAT_RESET = 3'd0;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	typedef enum logic [2:0] {
		FMT_RGB24  = 3'd0,
		FMT_BGR24  = 3'd1,
		FMT_RGBX32 = 3'd2,
		FMT_BGRX32 = 3'd3,
		FMT_RGBA32 = 3'd4
	} pix_fmt_t;

	typedef struct packed {
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  src_red;
		logic [7:0]  src_green;
		logic [7:0]  src_blue;
		logic [7:0]  src_alpha;
		logic [7:0]  dst_byte0;
		logic [7:0]  dst_byte1;
		logic [7:0]  dst_byte2;
		logic [7:0]  dst_byte3;
	} plot_t;

	typedef struct packed {
		logic [25:0] byte_offset;
		logic        write_enable;
		logic [7:0]  out_byte0;
		logic [7:0]  out_byte1;
		logic [7:0]  out_byte2;
		logic [7:0]  out_byte3;
	} wback_t;

	// floor(n / 255) for a 16-bit value: estimate, then one correction
	function automatic logic [15:0] div255_16(input logic [15:0] n);
		logic [16:0] s;
		logic [8:0]  q0;
		logic [16:0] r;
		s  = 17'(n) + 17'(n >> 8);
		q0 = s[16:8];
		r  = 17'(n) - ({q0, 8'd0} - 17'(q0));
		if (r >= 17'd255) begin
			return 16'(q0) + 16'd1;
		end
		return 16'(q0);
	endfunction

	// floor(n / 255) for a 24-bit value: estimate, then one correction
	function automatic logic [16:0] div255_24(input logic [23:0] n);
		logic [24:0] s;
		logic [16:0] q0;
		logic [24:0] r;
		s  = 25'(n) + 25'(n >> 8) + 25'(n >> 16);
		q0 = s[24:8];
		r  = 25'(n) - ({q0, 8'd0} - 25'(q0));
		if (r >= 25'd255) begin
			return q0 + 17'd1;
		end
		return q0;
	endfunction

endpackage
`default_nettype wire

// ===== sv/pixel_alpha_blend_write.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_alpha_blend_write
// Source-over alpha blend of one plotted pixel into a packed destination
// pixel, with the pixel's byte offset in the frame.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  plot      in         plot_valid / plot_ready   plot_t
//  wback     out        wback_valid / wback_ready wback_t
//  config    in         APB write / read          pixel_format, frame_width,
//                                                 frame_height
//
//  One item per clock sustained while wback_ready is high; wback_valid follows
//  acceptance through the four pipeline stages (products, wide products,
//  first divide by 255, second divide and repack).
//  Reset clears the stage valid bits and loads the register defaults.
//  A stall on wback_ready holds each full stage with no empty stage ahead; empty stages still fill.
// ----------------------------------------------------------------------------
module pixel_alpha_blend_write
	import pab_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  plot_valid,
	output logic                       plot_ready,
	input  wire plot_t                 plot,

	output logic                       wback_valid,
	input  wire logic                  wback_ready,
	output wback_t                     wback,

	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	typedef struct packed {
		logic bgr;
		logic rgba;
		logic xpad;
		logic size4;
		logic drop;
		logic clear;
	} ctl_t;

	// configuration registers
	logic [2:0]       pixel_format_q;
	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FORMAT_RESET;
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_PIXEL_FORMAT: pixel_format_q <= pwdata[2:0];
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_PIXEL_FORMAT: prdata = APB_DATA_W'(pixel_format_q);
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// stage handshake
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4     = !vld_s4 || wback_ready;
	assign adv_s3     = !vld_s3 || adv_s4;
	assign adv_s2     = !vld_s2 || adv_s3;
	assign adv_s1     = !vld_s1 || adv_s2;
	assign plot_ready = adv_s1;
	assign wback_valid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= plot_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
		end
	end

	// stage 1: decode, unpack, 8x8 products, row base
	logic [DIM_W-1:0] w_eff, h_eff;
	logic             fmt_ok, in_frame;
	ctl_t             ctl_in;
	logic [7:0]       da_in, inv_in;
	logic [7:0]       cs_in [3];
	logic [7:0]       cd_in [3];

	always_comb begin
		w_eff = (frame_width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_width_q;
		h_eff = (frame_height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_height_q;
		fmt_ok = pixel_format_q <= FMT_RGBA32;
		in_frame = (DIM_W'(plot.pos_x) < w_eff) && (DIM_W'(plot.pos_y) < h_eff);
		ctl_in.bgr   = (pixel_format_q == FMT_BGR24) || (pixel_format_q == FMT_BGRX32);
		ctl_in.rgba  = pixel_format_q == FMT_RGBA32;
		ctl_in.xpad  = (pixel_format_q == FMT_RGBX32) || (pixel_format_q == FMT_BGRX32);
		ctl_in.size4 = pixel_format_q >= FMT_RGBX32;
		ctl_in.drop  = !fmt_ok || !in_frame;
		ctl_in.clear = plot.src_alpha == 8'h00;
		da_in  = ctl_in.rgba ? plot.dst_byte3 : 8'hFF;
		inv_in = 8'hFF - plot.src_alpha;
		cs_in[0] = plot.src_red;
		cs_in[1] = plot.src_green;
		cs_in[2] = plot.src_blue;
		cd_in[0] = ctl_in.bgr ? plot.dst_byte2 : plot.dst_byte0;
		cd_in[1] = plot.dst_byte1;
		cd_in[2] = ctl_in.bgr ? plot.dst_byte0 : plot.dst_byte2;
	end

	ctl_t        ctl_s1;
	logic [7:0]  sa_s1;
	logic [7:0]  cd_s1 [3];
	logic [15:0] ps_s1 [3];
	logic [15:0] dainv_s1;
	logic [24:0] wy_s1;
	logic [11:0] x_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ctl_s1   <= ctl_in;
			sa_s1    <= plot.src_alpha;
			dainv_s1 <= 16'(da_in) * 16'(inv_in);
			wy_s1    <= 25'(w_eff) * 25'(plot.pos_y);
			x_s1     <= plot.pos_x;
			for (int i = 0; i < 3; i++) begin
				cd_s1[i] <= cd_in[i];
				ps_s1[i] <= 16'(cs_in[i]) * 16'(plot.src_alpha);
			end
		end
	end

	// stage 2: destination products, source terms, alpha, linear index
	ctl_t        ctl_s2;
	logic [7:0]  qs_s2 [3];
	logic [23:0] pd_s2 [3];
	logic [7:0]  alpha_s2;
	logic [24:0] lin_s2;
	logic [15:0] adiv;

	assign adiv = div255_16(dainv_s1);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ctl_s2   <= ctl_s1;
			alpha_s2 <= sa_s1 + adiv[7:0];
			lin_s2   <= wy_s1 + 25'(x_s1);
			for (int i = 0; i < 3; i++) begin
				qs_s2[i] <= 8'(div255_16(ps_s1[i]));
				pd_s2[i] <= 24'(cd_s1[i]) * 24'(dainv_s1);
			end
		end
	end

	// stage 3: first divide of destination terms, byte offset
	ctl_t        ctl_s3;
	logic [7:0]  qs_s3 [3];
	logic [15:0] qd1_s3 [3];
	logic [7:0]  alpha_s3;
	logic [25:0] ofs_s3;
	logic [26:0] ofs_full;

	assign ofs_full = ctl_s2.size4 ? {lin_s2, 2'b00}
	                               : (27'(lin_s2) + {1'b0, lin_s2, 1'b0});

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			ctl_s3   <= ctl_s2;
			alpha_s3 <= alpha_s2;
			ofs_s3   <= ofs_full[25:0];
			for (int i = 0; i < 3; i++) begin
				qs_s3[i]  <= qs_s2[i];
				qd1_s3[i] <= 16'(div255_24(pd_s2[i]));
			end
		end
	end

	// stage 4: second divide, sum, repack
	logic [7:0] chan [3];
	logic [8:0] sum;
	logic [15:0] qd;
	wback_t     res;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qd      = div255_16(qd1_s3[i]);
			sum     = 9'(qs_s3[i]) + 9'(qd[7:0]);
			chan[i] = sum[7:0];
		end
		res = '0;
		if (!ctl_s3.drop) begin
			res.byte_offset = ofs_s3;
			if (!ctl_s3.clear) begin
				res.write_enable = 1'b1;
				res.out_byte0    = ctl_s3.bgr ? chan[2] : chan[0];
				res.out_byte1    = chan[1];
				res.out_byte2    = ctl_s3.bgr ? chan[0] : chan[2];
				res.out_byte3    = ctl_s3.rgba ? alpha_s3 : (ctl_s3.xpad ? 8'hFF : 8'h00);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			wback <= res;
		end
	end

endmodule
`default_nettype wire

// ===== tb/pab_wback_checker.sv =====
// ----------------------------------------------------------------------------
// pab_wback_checker
// Watches the plot, write-back and register ports of the alpha blend pixel
// writer. It keeps its own copy of the frame registers and blends every
// accepted plot item into the expected write-back item. Each write-back item
// is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module pab_wback_checker
	import pab_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  plot_valid,
	input  wire logic                  plot_ready,
	input  wire plot_t                 plot,
	input  wire logic                  wback_valid,
	input  wire logic                  wback_ready,
	input  wire wback_t                wback,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic                  pready,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output int                         fail_count,
	output int                         pending,
	output int                         checked
);

	localparam int unsigned FULL = 255;

	logic [2:0]       cur_format;
	logic [DIM_W-1:0] cur_width;
	logic [DIM_W-1:0] cur_height;
	wback_t           wback_expect_q[$];

	function automatic int unsigned mix_channel(input int unsigned cs, input int unsigned sa,
			input int unsigned cd, input int unsigned da);
		return (cs * sa) / FULL + (cd * da * (FULL - sa)) / (FULL * FULL);
	endfunction

	function automatic wback_t blend_pixel(input plot_t p);
		wback_t      r;
		int unsigned w, h, size, sa, da, dr, dg, db, cr, cg, cb, ca;
		logic        bgr;
		r = '0;
		w = (cur_width > MAX_DIM) ? MAX_DIM : cur_width;
		h = (cur_height > MAX_DIM) ? MAX_DIM : cur_height;
		if (cur_format > FMT_RGBA32 || p.pos_x >= w || p.pos_y >= h) begin
			return r;
		end
		bgr  = (cur_format == FMT_BGR24 || cur_format == FMT_BGRX32);
		size = (cur_format == FMT_RGB24 || cur_format == FMT_BGR24) ? 3 : 4;
		r.byte_offset = 26'((w * p.pos_y + p.pos_x) * size);
		sa = p.src_alpha;
		if (sa == 0) begin
			return r;
		end
		dr = bgr ? p.dst_byte2 : p.dst_byte0;
		dg = p.dst_byte1;
		db = bgr ? p.dst_byte0 : p.dst_byte2;
		da = (cur_format == FMT_RGBA32) ? p.dst_byte3 : FULL;
		if (sa == FULL) begin
			cr = p.src_red;
			cg = p.src_green;
			cb = p.src_blue;
			ca = FULL;
		end else begin
			cr = mix_channel(p.src_red, sa, dr, da);
			cg = mix_channel(p.src_green, sa, dg, da);
			cb = mix_channel(p.src_blue, sa, db, da);
			ca = sa + (da * (FULL - sa)) / FULL;
		end
		r.write_enable = 1'b1;
		r.out_byte0 = 8'(bgr ? cb : cr);
		r.out_byte1 = 8'(cg);
		r.out_byte2 = 8'(bgr ? cr : cb);
		if (cur_format == FMT_RGBA32) begin
			r.out_byte3 = 8'(ca);
		end else if (cur_format >= FMT_RGBX32) begin
			r.out_byte3 = 8'hFF;
		end else begin
			r.out_byte3 = 8'h00;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wback_t want;
		int     errs;
		errs = 0;
		if (!arst_n) begin
			cur_format <= FORMAT_RESET;
			cur_width  <= WIDTH_RESET;
			cur_height <= HEIGHT_RESET;
			wback_expect_q.delete();
			pending    <= 0;
			checked    <= 0;
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					{REG_PIXEL_FORMAT, 2'b00}: cur_format <= pwdata[2:0];
					{REG_FRAME_WIDTH, 2'b00}:  cur_width  <= pwdata[DIM_W-1:0];
					{REG_FRAME_HEIGHT, 2'b00}: cur_height <= pwdata[DIM_W-1:0];
					default: ;
				endcase
			end
			if (wback_valid && wback_ready) begin
				if (wback_expect_q.size() == 0) begin
					$error("write-back item with none expected: byte_offset %0d", wback.byte_offset);
					errs++;
				end else begin
					want = wback_expect_q.pop_front();
					if (wback.byte_offset !== want.byte_offset) begin
						$error("byte_offset: expected %0d, got %0d", want.byte_offset,
							wback.byte_offset);
						errs++;
					end
					if (wback.write_enable !== want.write_enable) begin
						$error("write_enable: expected %0d, got %0d", want.write_enable,
							wback.write_enable);
						errs++;
					end
					if (wback.out_byte0 !== want.out_byte0) begin
						$error("out_byte0: expected %0d, got %0d", want.out_byte0, wback.out_byte0);
						errs++;
					end
					if (wback.out_byte1 !== want.out_byte1) begin
						$error("out_byte1: expected %0d, got %0d", want.out_byte1, wback.out_byte1);
						errs++;
					end
					if (wback.out_byte2 !== want.out_byte2) begin
						$error("out_byte2: expected %0d, got %0d", want.out_byte2, wback.out_byte2);
						errs++;
					end
					if (wback.out_byte3 !== want.out_byte3) begin
						$error("out_byte3: expected %0d, got %0d", want.out_byte3, wback.out_byte3);
						errs++;
					end
					checked <= checked + 1;
				end
			end
			if (plot_valid && plot_ready) begin
				wback_expect_q.push_back(blend_pixel(plot));
			end
			pending    <= wback_expect_q.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives plot items and register writes into the alpha blend pixel writer
// with random bursts and write-back stalls, and reports the verdict from the
// checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
	import pab_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int RAND_FRAMES     = 10;
	localparam int ITEMS_PER_FRAME = 125;
	localparam int SETTLE_CYCLES   = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  plot_valid;
	logic                  plot_ready;
	plot_t                 plot;
	logic                  wback_valid;
	logic                  wback_ready;
	wback_t                wback;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int          fail_count;
	int          pending;
	int          checked;
	int          items_sent = 0;
	int          frames_loaded = 0;
	int          idle_cycles = 0;
	int unsigned frame_w_eff;
	int unsigned frame_h_eff;

	pixel_alpha_blend_write dut (.*);

	pab_wback_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic plot_t mk_plot(input logic [11:0] x, input logic [11:0] y,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, input logic [7:0] a,
			input logic [7:0] d0, input logic [7:0] d1, input logic [7:0] d2,
			input logic [7:0] d3);
		return '{x, y, r, g, b, a, d0, d1, d2, d3};
	endfunction

	function automatic logic [11:0] pick_coord(input int unsigned dim);
		case ($urandom_range(0, 9))
			0: return 12'($urandom);
			1: return (dim == 0) ? 12'd0 : 12'(dim - 1);
			2: return (dim >= MAX_DIM) ? 12'd4095 : 12'(dim);
			default: return (dim == 0) ? 12'($urandom) : 12'($urandom_range(0, dim - 1));
		endcase
	endfunction

	function automatic logic [7:0] pick_alpha();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_dim();
		case ($urandom_range(0, 7))
			0: return 1;
			1: return MAX_DIM;
			2: return $urandom_range(MAX_DIM + 1, 8191);
			3: return $urandom_range(1, 16);
			default: return $urandom_range(1, MAX_DIM);
		endcase
	endfunction

	task automatic plot_pixel(input plot_t p);
		@(negedge clk);
		plot_valid <= 1'b1;
		plot <= p;
		do @(posedge clk); while (!plot_ready);
		items_sent++;
	endtask

	task automatic hold_plots(input int n);
		repeat (n) begin
			@(negedge clk);
			plot_valid <= 1'b0;
			plot <= plot_t'({$urandom, $urandom, $urandom});
		end
	endtask

	task automatic drain_plots();
		@(negedge clk);
		plot_valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_frame(input logic [2:0] fmt, input int unsigned w, input int unsigned h);
		logic [APB_DATA_W-1:0] noise;
		drain_plots();
		noise = ($urandom_range(0, 1) == 1) ? $urandom : '0;
		apb_write(REG_PIXEL_FORMAT, {noise[31:3], fmt});
		apb_write(REG_FRAME_WIDTH, {noise[31:13], 13'(w)});
		apb_write(REG_FRAME_HEIGHT, {noise[31:13], 13'(h)});
		frame_w_eff = (13'(w) > MAX_DIM) ? MAX_DIM : 13'(w);
		frame_h_eff = (13'(h) > MAX_DIM) ? MAX_DIM : 13'(h);
		frames_loaded++;
	endtask

	initial begin
		int         burst;
		logic [2:0] fmt;
		plot_valid = 1'b0;
		plot = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		frame_w_eff = WIDTH_RESET;
		frame_h_eff = HEIGHT_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		plot_pixel(mk_plot(0, 0, 8'h12, 8'h34, 8'h56, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
		plot_pixel(mk_plot(639, 479, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h00, 8'hFF));
		plot_pixel(mk_plot(640, 0, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44));
		plot_pixel(mk_plot(0, 480, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44));
		plot_pixel(mk_plot(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		plot_pixel(mk_plot(5, 5, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hAA, 8'hAA, 8'hAA, 8'hAA));

		load_frame(FMT_RGBA32, 8191, MAX_DIM);
		plot_pixel(mk_plot(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		plot_pixel(mk_plot(0, 0, 8'hFF, 8'h00, 8'hFF, 8'hFE, 8'h00, 8'hFF, 8'h00, 8'h00));
		plot_pixel(mk_plot(100, 200, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78));
		plot_pixel(mk_plot(1, 1, 8'h55, 8'h55, 8'h55, 8'h00, 8'h66, 8'h77, 8'h88, 8'h99));

		load_frame(FMT_BGR24, 0, 1);
		plot_pixel(mk_plot(0, 0, 8'h80, 8'h40, 8'h20, 8'h80, 8'h10, 8'h20, 8'h30, 8'h40));

		load_frame(FMT_BGRX32, 1, 1);
		plot_pixel(mk_plot(0, 0, 8'h10, 8'h20, 8'h30, 8'h4D, 8'hF0, 8'hE0, 8'hD0, 8'hC0));
		plot_pixel(mk_plot(1, 0, 8'h10, 8'h20, 8'h30, 8'h4D, 8'hF0, 8'hE0, 8'hD0, 8'hC0));

		load_frame(FMT_RGBX32, MAX_DIM, 8191);
		plot_pixel(mk_plot(4095, 4095, 8'hAA, 8'hBB, 8'hCC, 8'hC8, 8'h11, 8'h22, 8'h33, 8'h44));

		for (int f = int'(FMT_RGBA32) + 1; f < 8; f++) begin
			load_frame(3'(f), 16, 16);
			plot_pixel(mk_plot(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04));
		end

		for (int ph = 0; ph < RAND_FRAMES; ph++) begin
			if (ph <= int'(FMT_RGBA32)) begin
				fmt = 3'(ph);
			end else if ($urandom_range(0, 9) == 0) begin
				fmt = 3'($urandom_range(int'(FMT_RGBA32) + 1, 7));
			end else begin
				fmt = 3'($urandom_range(int'(FMT_RGB24), int'(FMT_RGBA32)));
			end
			load_frame(fmt, pick_dim(), pick_dim());
			burst = 0;
			for (int n = 0; n < ITEMS_PER_FRAME; n++) begin
				if (burst == 0) begin
					burst = $urandom_range(1, 40);
					hold_plots(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10));
				end
				burst--;
				plot_pixel(mk_plot(pick_coord(frame_w_eff), pick_coord(frame_h_eff),
					8'($urandom), 8'($urandom), 8'($urandom), pick_alpha(),
					8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
			end
		end

		drain_plots();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		$display("Plotted %0d items, checked %0d write-back items over %0d register settings",
			items_sent, checked, frames_loaded);
		$display("Layouts cover all eight codes; frame sizes from zero past saturation");
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		int run;
		int mode;
		wback_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 9);
			run = (mode < 4) ? $urandom_range(1, 50) :
				(mode < 7) ? $urandom_range(1, 12) : $urandom_range(4, 30);
			repeat (run) begin
				@(negedge clk);
				if (mode < 4) begin
					wback_ready <= 1'b1;
				end else if (mode < 7) begin
					wback_ready <= 1'b0;
				end else begin
					wback_ready <= 1'($urandom);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((plot_valid && plot_ready) || (wback_valid && wback_ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
